// File: hdl/nsos_pkg.sv
package nsos_pkg;

  localparam int unsigned MaxSamples  = 16;
  localparam int unsigned MaxDims     = 8;
  localparam int unsigned FeatureBits = 16;

  localparam int unsigned SumBits   = 36;
  localparam int unsigned ScoreBits = 19;
  localparam int unsigned IdBits    = 32;

  // Configuration register indexes
  localparam logic CfgSamplesInUse = 1'b0;
  localparam logic CfgDimsInUse    = 1'b1;

  // Input item kinds
  localparam logic KindLoad  = 1'b0;
  localparam logic KindPoint = 1'b1;

  // Point component moving along the cell row
  typedef struct packed {
    logic        valid;
    logic        first;
    logic        last;
    logic [2:0]  comp;
    logic [31:0] obj;
    logic [31:0] value;
  } nsos_tok_t;

  // Running minimum moving along the cell row behind the last component
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [SumBits-1:0] best;
    logic [31:0]        obj;
  } nsos_min_t;

endpackage

// File: hdl/nsos_cell.sv
module nsos_cell #(
  parameter int unsigned MaxDims     = nsos_pkg::MaxDims,
  parameter int unsigned FeatureBits = nsos_pkg::FeatureBits,
  parameter int unsigned CellIdx     = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [8:0]           n_samples_i,
  input  logic                 load_i,
  input  logic [2:0]           load_comp_i,
  input  logic [31:0]          load_obj_i,
  input  logic [31:0]          load_value_i,
  input  nsos_pkg::nsos_tok_t  tok_i,
  input  nsos_pkg::nsos_min_t  min_i,
  output nsos_pkg::nsos_tok_t  tok_o,
  output nsos_pkg::nsos_min_t  min_o
);
  import nsos_pkg::*;

  localparam int unsigned CompBits = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam logic [SumBits-1:0] SumMax = '1;

  logic signed [FeatureBits-1:0] vals_q [MaxDims];
  logic [31:0]                   id_q;
  logic [SumBits-1:0]            sum_q, sum_d;
  logic                          active;
  logic signed [FeatureBits:0]   diff;
  logic [FeatureBits:0]          mag;
  logic [2*FeatureBits+1:0]      sq;
  logic [SumBits:0]              add;
  logic [SumBits-1:0]            base;
  nsos_tok_t                     tok_q;
  nsos_min_t                     min_q, min_d;

  assign active = (9'(CellIdx) < n_samples_i);

  // Store sample components and tag
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vals_q[load_comp_i[CompBits-1:0]] <= load_value_i[FeatureBits-1:0];
      id_q <= load_obj_i;
    end
  end

  // Squared difference for the passing component; clear as the minimum passes
  always_comb begin
    diff = $signed({tok_i.value[FeatureBits-1], tok_i.value[FeatureBits-1:0]})
         - $signed({vals_q[tok_i.comp[CompBits-1:0]][FeatureBits-1],
                    vals_q[tok_i.comp[CompBits-1:0]]});
    mag  = diff[FeatureBits] ? (FeatureBits+1)'(-diff) : diff;
    sq   = (2*FeatureBits+2)'(mag) * (2*FeatureBits+2)'(mag);
    if (id_q == tok_i.obj) sq = '0;
    base = tok_i.first ? '0 : sum_q;
    if (sq > (2*FeatureBits+2)'(SumMax)) add = {1'b1, SumMax};
    else add = {1'b0, base} + (SumBits+1)'(sq);
    sum_d = sum_q;
    if (min_i.valid) sum_d = '0;
    else if (tok_i.valid) sum_d = add[SumBits] ? SumMax : add[SumBits-1:0];
  end

  // Fold this cell's sum into the running minimum
  always_comb begin
    min_d = min_i;
    if (min_i.valid && active && id_q != min_i.obj && sum_q != '0 &&
        (!min_i.found || sum_q < min_i.best)) begin
      min_d.found = 1'b1;
      min_d.best  = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      tok_q <= '0;
      min_q <= '0;
    end else begin
      sum_q <= sum_d;
      tok_q <= tok_i;
      min_q <= min_d;
    end
  end

  assign tok_o = tok_q;
  assign min_o = min_q;

  // Minimum token arrives in the cycle after the last component
  a_min_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.valid && tok_i.last |=> min_i.valid)
    else $error("min order");
  a_sum_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(tok_i.valid) && !$past(tok_i.first) |-> sum_q >= $past(sum_q))
    else $error("sum decreased without restart");
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tok_i.valid && !min_i.valid |=> $stable(sum_q))
    else $error("sum changed while idle");

endmodule

// File: hdl/nsos_isqrt.sv
module nsos_isqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [nsos_pkg::SumBits-1:0]      x_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [nsos_pkg::ScoreBits-1:0]    root_o
);
  import nsos_pkg::*;

  localparam int unsigned Steps = SumBits / 2;

  logic [SumBits-1:0] rem_q, rem_d;
  logic [SumBits-1:0] r_q, r_d;
  logic [SumBits-1:0] bit_q, bit_d;
  logic               busy_q, done_q;
  logic [SumBits-1:0] trial;

  // One bit pair per cycle, restoring method
  always_comb begin
    trial = r_q + bit_q;
    rem_d = rem_q;
    r_d   = r_q >> 1;
    if (rem_q >= trial) begin
      rem_d = rem_q - trial;
      r_d   = (r_q >> 1) + bit_q;
    end
    bit_d = bit_q >> 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) busy_q <= 1'b1;
      else if (busy_q && bit_q == SumBits'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= x_i;
      r_q   <= '0;
      bit_q <= SumBits'(1) << (2*(Steps-1));
    end else if (busy_q) begin
      rem_q <= rem_d;
      r_q   <= r_d;
      bit_q <= bit_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = r_q[ScoreBits-1:0];

endmodule

// File: hdl/nearest_sample_outlier_score_core.sv
// Nearest-sample outlier scorer. Sample components load into a row of
// MAX_SAMPLES cells (kind 0); a load waits while point components are still
// moving down the row. Point components (kind 1) flow down the row, one cell
// per cycle, each cell adding its squared distance. The component that ends
// a point is followed by a minimum token that walks the row and then an
// 18-step square root. A point component is taken every cycle except while
// the final component of a point is in flight: the result appears after the
// square root is done, and input is held off until the result is taken.
// Output sits in a register.
module nearest_sample_outlier_score_core #(
  parameter int unsigned MaxSamples  = nsos_pkg::MaxSamples,
  parameter int unsigned MaxDims     = nsos_pkg::MaxDims,
  parameter int unsigned FeatureBits = nsos_pkg::FeatureBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [4:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   kind_i,
  input  logic [31:0]            object_index_i,
  input  logic [3:0]             slot_i,
  input  logic [2:0]             component_i,
  input  logic [FeatureBits-1:0] feature_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [31:0]            point_index_o,
  output logic [18:0]            score_o,
  output logic                   found_o
);
  import nsos_pkg::*;

  logic [4:0] ns_q;
  logic [3:0] nd_q;
  logic [8:0] ns_eff;
  logic [6:0] nd_eff;
  logic       in_acc, busy_q, pend_q;
  logic       row_busy;

  nsos_tok_t tok  [MaxSamples+1];
  nsos_min_t minr [MaxSamples+1];
  nsos_min_t min_hold_q;

  logic       sq_start, sq_busy, sq_done;
  logic [18:0] sq_root;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q <= 5'd16;
      nd_q <= 4'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSamplesInUse: ns_q <= cfg_data_i;
        CfgDimsInUse:    nd_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamp registers
  assign ns_eff = (ns_q == 0) ? 9'd1 :
                  (9'(ns_q) > 9'(MaxSamples)) ? 9'(MaxSamples) : 9'(ns_q);
  assign nd_eff = (nd_q == 0) ? 7'd1 :
                  (7'(nd_q) > 7'(MaxDims)) ? 7'(MaxDims) : 7'(nd_q);

  // Flag point components still on their way down the row
  always_comb begin
    row_busy = 1'b0;
    for (int k = 1; k < MaxSamples; k++) row_busy = row_busy | tok[k].valid;
  end

  assign in_ready_o = !busy_q && !(kind_i == KindLoad && row_busy);
  assign in_acc     = in_valid_i && in_ready_o;

  // Inject point components
  always_comb begin
    tok[0].valid = in_acc && kind_i == KindPoint && 7'(component_i) < nd_eff;
    tok[0].first = component_i == 3'd0;
    tok[0].last  = 7'(component_i) == nd_eff - 7'd1;
    tok[0].comp  = component_i;
    tok[0].obj   = object_index_i;
    tok[0].value = 32'(feature_value_i);
    minr[0]      = min_hold_q;
  end

  // Minimum token starts in the cycle after the last component
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_hold_q <= '0;
    end else begin
      min_hold_q.valid <= tok[0].valid && tok[0].last;
      min_hold_q.found <= 1'b0;
      min_hold_q.best  <= '0;
      min_hold_q.obj   <= object_index_i;
    end
  end

  for (genvar g = 0; g < MaxSamples; g++) begin : g_cell
    nsos_cell #(
      .MaxDims    (MaxDims),
      .FeatureBits(FeatureBits),
      .CellIdx    (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .n_samples_i (ns_eff),
      .load_i      (in_acc && kind_i == KindLoad && 32'(slot_i) == g &&
                    32'(component_i) < MaxDims),
      .load_comp_i (component_i),
      .load_obj_i  (object_index_i),
      .load_value_i(32'(feature_value_i)),
      .tok_i       (tok[g]),
      .min_i       (minr[g]),
      .tok_o       (tok[g+1]),
      .min_o       (minr[g+1])
    );
  end

  assign sq_start = minr[MaxSamples].valid;

  nsos_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .x_i    (minr[MaxSamples].best),
    .busy_o (sq_busy),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  // Hold input from a final component until the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (tok[0].valid && tok[0].last) busy_q <= 1'b1;
      if (sq_start) pend_q <= minr[MaxSamples].found;
      if (sq_done) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
        busy_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) point_index_o <= minr[MaxSamples].obj;
    if (sq_done) begin
      score_o <= pend_q ? sq_root : '0;
      found_o <= pend_q;
    end
  end

  a_out_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_q) else $error("result without pending point");
  a_no_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_busy |-> !in_ready_o) else $error("input taken during root");
  a_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |=> out_valid_o) else $error("result lost");

endmodule
